// ===== rtl/core/ohs_pkg.sv =====
package ohs_pkg;

   localparam int KEY_W  = 64;
   localparam int HASH_W = 64;
   localparam logic [HASH_W-1:0] HASH_SEED = 64'd97;

   typedef enum logic [1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_ABSENT    = 2'd1,
      ST_EMPTY_KEY = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_LIVE  = 2'd1;
   localparam logic [1:0] MARK_TOMB  = 2'd2;

   typedef struct packed {
      func_type          func;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] hash;
      logic              key_empty;
   } job_type;

endpackage

// ===== rtl/core/open_address_hash_set_unit.sv =====
// Flow: hash the key bytes, reduce modulo the table size, set up and probe,
// write where needed, then the result waits in the output register.
// Throughput: one request at a time in the back end (modulo and probe loop);
// the front hashes the next request meanwhile, through a two-entry queue.
// Reset: synchronous; then the back end clears the slot mark of every address;
// requests taken in meanwhile wait in the front and the queue.
module open_address_hash_set_unit
   import ohs_pkg::*;
#(
   parameter int MAX_SLOTS = 256,
   parameter int KEY_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [8:0]        csr_wdata,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_func,
   input  logic [KEY_W-1:0]  req_key,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_slot,
   output logic [8:0]        rsp_entry_count
);

   logic [8:0] size_ff;
   logic       f_valid, f_ready, b_valid, b_ready;
   job_type    f_job, b_job;

   always_ff @(posedge clock) begin
      if (reset) size_ff <= 9'd256;
      else if (csr_we) size_ff <= csr_wdata;
   end

   ohs_front #(.KEY_BYTES(KEY_BYTES)) u_front (
      .clock, .reset, .req_push, .req_full, .req_func, .req_key,
      .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

   ohs_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
      .out_valid(b_valid), .out_ready(b_ready), .out_job(b_job));

   ohs_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
      .clock, .reset, .csr_table_size(size_ff),
      .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
      .rsp_empty, .rsp_pop, .rsp_status, .rsp_slot, .rsp_entry_count);

endmodule

// ===== rtl/core/ohs_front.sv =====
module ohs_front
   import ohs_pkg::*;
#(
   parameter int KEY_BYTES = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [1:0]        req_func,
   input  logic [KEY_W-1:0]  req_key,
   output logic              job_valid,
   input  logic              job_ready,
   output job_type           job
);

   localparam int CW = $clog2(KEY_BYTES + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [KEY_W-1:0]  raw_ff, raw_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [1:0]        func_ff, func_in;
   logic [7:0]        byte_cur;

   assign req_full  = busy_ff;
   assign job_valid = done_ff;
   assign byte_cur  = raw_ff[8*idx_ff[CW-1:0] +: 8];
   assign job.func      = func_type'(func_ff);
   assign job.key       = key_ff;
   assign job.hash      = hash_ff;
   assign job.key_empty = (key_ff == '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      idx_in  = idx_ff;
      raw_in  = raw_ff;
      key_in  = key_ff;
      hash_in = hash_ff;
      func_in = func_ff;
      if (!busy_ff) begin
         if (req_push) begin
            busy_in = 1'b1;
            done_in = 1'b0;
            idx_in  = '0;
            raw_in  = req_key;
            key_in  = '0;
            hash_in = HASH_SEED;
            func_in = req_func;
         end
      end else if (!done_ff) begin
         if (32'(idx_ff) >= KEY_BYTES || byte_cur == 8'd0) begin
            done_in = 1'b1;
         end else begin
            hash_in = (hash_ff << 5) + hash_ff + HASH_W'(byte_cur);
            key_in  = key_ff | (KEY_W'(byte_cur) << (8 * idx_ff));
            idx_in  = idx_ff + 1'b1;
         end
      end else if (job_ready) begin
         done_in = 1'b0;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff  <= idx_in;
      raw_ff  <= raw_in;
      key_ff  <= key_in;
      hash_ff <= hash_in;
      func_ff <= func_in;
   end

endmodule

// ===== rtl/core/ohs_back.sv =====
module ohs_back
   import ohs_pkg::*;
#(
   parameter int MAX_SLOTS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [8:0]        csr_table_size,
   input  logic              job_valid,
   output logic              job_ready,
   input  job_type           job,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_slot,
   output logic [8:0]        rsp_entry_count
);

   localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int NW = $clog2(MAX_SLOTS + 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_MOD, S_READ, S_PROBE, S_WRITE, S_OUT
   } state_type;

   state_type         state_ff;
   logic [KEY_W-1:0]  keys_mem [MAX_SLOTS];
   logic [1:0]        marks_mem [MAX_SLOTS];
   logic [KEY_W-1:0]  rd_key_ff;
   logic [1:0]        rd_mark_ff;
   logic [AW-1:0]     addr_ff, start_ff, pos_ff, free_ff;
   logic              free_ok_ff;
   logic [NW-1:0]     steps_ff, n_ff;
   logic [HASH_W+NW-1:0] rem_ff;
   logic [6:0]        mbit_ff;
   job_type           job_ff;
   logic [8:0]        count_ff;
   logic [1:0]        st_ff;
   logic [7:0]        slot_ff;
   logic              full_wr_ff;
   logic [1:0]        wr_mark_ff;
   logic [NW-1:0]     n_use;
   logic [AW-1:0]     pos_nx;
   logic [HASH_W+NW-1:0] trial;

   assign job_ready       = (state_ff == S_IDLE);
   assign rsp_empty       = (state_ff != S_OUT);
   assign rsp_status      = st_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_entry_count = count_ff;

   always_comb begin
      if (csr_table_size == 9'd0)
         n_use = NW'(1);
      else if (32'(csr_table_size) > MAX_SLOTS)
         n_use = NW'(MAX_SLOTS);
      else
         n_use = NW'(csr_table_size);
      pos_nx = (32'(pos_ff) + 1 >= 32'(n_ff)) ? '0 : pos_ff + 1'b1;
      trial  = (HASH_W+NW)'(n_ff) << mbit_ff;
   end

   always_ff @(posedge clock) begin
      rd_key_ff  <= keys_mem[addr_ff];
      rd_mark_ff <= marks_mem[addr_ff];
      if (state_ff == S_CLEAR) marks_mem[addr_ff] <= MARK_EMPTY;
      if (state_ff == S_WRITE) begin
         marks_mem[addr_ff] <= wr_mark_ff;
         if (full_wr_ff) keys_mem[addr_ff] <= job_ff.key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff  <= '0;
         count_ff <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               if (32'(addr_ff) == MAX_SLOTS - 1) state_ff <= S_IDLE;
            end
            S_IDLE: if (job_valid) begin
               job_ff   <= job;
               n_ff     <= n_use;
               rem_ff   <= (HASH_W+NW)'(job.hash);
               mbit_ff  <= 7'(HASH_W - 1);
               state_ff <= S_MOD;
            end
            S_MOD: begin
               if (trial <= rem_ff && (trial >> mbit_ff) == (HASH_W+NW)'(n_ff))
                  rem_ff <= rem_ff - trial;
               if (mbit_ff == 7'd0) begin
                  state_ff <= S_READ;
               end
               mbit_ff <= mbit_ff - 7'd1;
               if (mbit_ff == 7'd0) begin
                  start_ff   <= '0;
               end
            end
            S_READ: begin
               if (job_ff.func == FUNC_INSERT && job_ff.key_empty) begin
                  st_ff <= ST_EMPTY_KEY; slot_ff <= '0; state_ff <= S_OUT;
               end else if (job_ff.func == FUNC_NONE) begin
                  st_ff <= ST_ABSENT; slot_ff <= '0; state_ff <= S_OUT;
               end else begin
                  start_ff   <= AW'(rem_ff);
                  pos_ff     <= AW'(rem_ff);
                  addr_ff    <= AW'(rem_ff);
                  steps_ff   <= '0;
                  free_ok_ff <= 1'b0;
                  full_wr_ff <= 1'b0;
                  state_ff   <= S_PROBE;
               end
            end
            S_PROBE: begin
               // memory read of addr_ff is registered; a pass with full_wr_ff low waits for it
               if (addr_ff == pos_ff && !full_wr_ff) begin
                  full_wr_ff <= 1'b1;
               end else begin
                  full_wr_ff <= 1'b0;
                  if (rd_mark_ff != MARK_LIVE && !free_ok_ff) begin
                     free_ok_ff <= 1'b1; free_ff <= pos_ff;
                  end
                  if (rd_mark_ff == MARK_EMPTY) begin
                     if (job_ff.func == FUNC_INSERT) begin
                        slot_ff <= 8'(free_ok_ff ? free_ff : pos_ff);
                        addr_ff <= free_ok_ff ? free_ff : pos_ff;
                        wr_mark_ff <= MARK_LIVE; full_wr_ff <= 1'b1;
                        st_ff <= ST_OK; count_ff <= count_ff + 9'd1;
                        state_ff <= S_WRITE;
                     end else begin
                        st_ff <= ST_ABSENT; slot_ff <= 8'(pos_ff); state_ff <= S_OUT;
                     end
                  end else if (rd_mark_ff == MARK_LIVE && rd_key_ff == job_ff.key) begin
                     slot_ff <= 8'(pos_ff);
                     if (job_ff.func == FUNC_REMOVE) begin
                        st_ff <= ST_OK; wr_mark_ff <= MARK_TOMB;
                        count_ff <= count_ff - 9'd1; state_ff <= S_WRITE;
                     end else begin
                        st_ff <= (job_ff.func == FUNC_LOOKUP) ? ST_OK : ST_ABSENT;
                        state_ff <= S_OUT;
                     end
                  end else if (32'(steps_ff) + 1 >= 32'(n_ff)) begin
                     if (job_ff.func == FUNC_INSERT &&
                         (free_ok_ff || rd_mark_ff != MARK_LIVE)) begin
                        slot_ff <= 8'(free_ok_ff ? free_ff : pos_ff);
                        addr_ff <= free_ok_ff ? free_ff : pos_ff;
                        wr_mark_ff <= MARK_LIVE; full_wr_ff <= 1'b1;
                        st_ff <= ST_OK; count_ff <= count_ff + 9'd1;
                        state_ff <= S_WRITE;
                     end else begin
                        st_ff <= (job_ff.func == FUNC_INSERT) ? ST_FULL : ST_ABSENT;
                        slot_ff <= 8'(start_ff); state_ff <= S_OUT;
                     end
                  end else begin
                     steps_ff <= steps_ff + 1'b1;
                     pos_ff   <= pos_nx;
                     addr_ff  <= pos_nx;
                  end
               end
            end
            S_WRITE: begin
               full_wr_ff <= 1'b0;
               state_ff   <= S_OUT;
            end
            S_OUT: if (rsp_pop) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/ohs_queue.sv =====
module ohs_queue
   import ohs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   logic [1:0] cnt_ff;
   job_type    q_ff [2];
   logic       rd_ff, wr_ff;
   logic       do_w, do_r;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_job   = q_ff[rd_ff];
   assign do_w = in_valid && in_ready;
   assign do_r = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; rd_ff <= 1'b0; wr_ff <= 1'b0;
      end else begin
         if (do_w) wr_ff <= ~wr_ff;
         if (do_r) rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, do_w} - {1'b0, do_r};
      end
      if (do_w) q_ff[wr_ff] <= in_job;
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

class hash_set_scoreboard;
   bit [63:0]  keys[256];
   bit [1:0]   marks[256];
   int unsigned live;
   int unsigned size_reg;
   bit [1:0]   exp_status[$];
   bit [7:0]   exp_slot[$];
   bit [8:0]   exp_count[$];
   int         errors;
   int         checked;

   function void clear();
      for (int i = 0; i < 256; i++) begin
         marks[i] = ohs_pkg::MARK_EMPTY;
         keys[i] = '0;
      end
      live = 0;
      size_reg = 256;
      errors = 0;
      checked = 0;
   endfunction

   function int unsigned eff_size();
      if (size_reg == 0) return 1;
      if (size_reg > 256) return 256;
      return size_reg;
   endfunction

   function bit search(bit [63:0] k, int unsigned start, int unsigned n, output int unsigned at);
      int unsigned p;
      p = start;
      for (int i = 0; i < n; i++) begin
         if (marks[p] == ohs_pkg::MARK_EMPTY) begin
            at = p;
            return 0;
         end
         if (marks[p] == ohs_pkg::MARK_LIVE && keys[p] == k) begin
            at = p;
            return 1;
         end
         p = (p + 1 >= n) ? 0 : p + 1;
      end
      at = start;
      return 0;
   endfunction

   function void note_request(ohs_pkg::func_type f, bit [63:0] raw);
      bit [63:0]   k;
      bit [63:0]   h;
      int unsigned len;
      int unsigned n;
      int unsigned start;
      int unsigned at;
      int unsigned p;
      bit [1:0]    st;
      bit [7:0]    sl;
      bit          hit;
      bit          placed;
      k = '0;
      len = 0;
      for (int i = 0; i < 8; i++) begin
         if (raw[8*i +: 8] == 8'd0) break;
         k[8*i +: 8] = raw[8*i +: 8];
         len = i + 1;
      end
      h = ohs_pkg::HASH_SEED;
      for (int i = 0; i < len; i++) h = (h << 5) + h + k[8*i +: 8];
      n = eff_size();
      start = 32'(h % n);
      st = ohs_pkg::ST_ABSENT;
      sl = 0;
      case (f)
         ohs_pkg::FUNC_LOOKUP: begin
            hit = search(k, start, n, at);
            st = hit ? ohs_pkg::ST_OK : ohs_pkg::ST_ABSENT;
            sl = 8'(at);
         end
         ohs_pkg::FUNC_INSERT: begin
            if (len == 0) begin
               st = ohs_pkg::ST_EMPTY_KEY;
            end else if (search(k, start, n, at)) begin
               sl = 8'(at);
            end else begin
               p = start;
               placed = 0;
               for (int i = 0; i < n; i++) begin
                  if (marks[p] != ohs_pkg::MARK_LIVE) begin
                     placed = 1;
                     break;
                  end
                  p = (p + 1 >= n) ? 0 : p + 1;
               end
               if (placed) begin
                  keys[p] = k;
                  marks[p] = ohs_pkg::MARK_LIVE;
                  live = (live + 1) & 9'h1ff;
                  st = ohs_pkg::ST_OK;
                  sl = 8'(p);
               end else begin
                  st = ohs_pkg::ST_FULL;
                  sl = 8'(start);
               end
            end
         end
         ohs_pkg::FUNC_REMOVE: begin
            hit = search(k, start, n, at);
            if (hit) begin
               marks[at] = ohs_pkg::MARK_TOMB;
               live = (live - 1) & 9'h1ff;
               st = ohs_pkg::ST_OK;
            end
            sl = 8'(at);
         end
         default: ;
      endcase
      exp_status.push_back(st);
      exp_slot.push_back(sl);
      exp_count.push_back(live[8:0]);
   endfunction

   function void check_response(bit [1:0] st, bit [7:0] sl, bit [8:0] cnt);
      bit [1:0] es;
      bit [7:0] esl;
      bit [8:0] ec;
      if (exp_status.size() == 0) begin
         $display("%0t: unexpected response status=%0d slot=%0d count=%0d", $time, st, sl, cnt);
         errors++;
         return;
      end
      es = exp_status.pop_front();
      esl = exp_slot.pop_front();
      ec = exp_count.pop_front();
      checked++;
      if (st !== es) begin
         $display("%0t: status expected %0d actual %0d", $time, es, st);
         errors++;
      end
      if (sl !== esl) begin
         $display("%0t: slot expected %0d actual %0d", $time, esl, sl);
         errors++;
      end
      if (cnt !== ec) begin
         $display("%0t: entry_count expected %0d actual %0d", $time, ec, cnt);
         errors++;
      end
   endfunction

   function int pending();
      return exp_status.size();
   endfunction
endclass

module tb_top;
   import ohs_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [8:0]  csr_wdata;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_func;
   logic [63:0] req_key;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_slot;
   logic [8:0]  rsp_entry_count;

   hash_set_scoreboard sb;
   bit [63:0] key_pool[32];
   int        burst_left;
   int        sent;

   open_address_hash_set_unit dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_push(req_push), .req_full(req_full), .req_func(req_func), .req_key(req_key),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_status(rsp_status),
      .rsp_slot(rsp_slot), .rsp_entry_count(rsp_entry_count)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #100_000_000;
      $display("tb_top failed");
      $finish;
   end

   // receiver: stalls in phases, some with no stall at all
   initial begin
      int mode;
      int cnt;
      rsp_pop = 1'b0;
      mode = 0;
      cnt = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            sb.check_response(rsp_status, rsp_slot, rsp_entry_count);
         if (cnt == 0) begin
            mode = $urandom_range(0, 3);
            cnt = $urandom_range(20, 300);
         end
         cnt--;
         case (mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= ($urandom_range(0, 3) != 0);
            2: rsp_pop <= ($urandom_range(0, 3) == 0);
            default: rsp_pop <= ($urandom_range(0, 40) == 0);
         endcase
      end
   end

   task automatic send(func_type f, bit [63:0] k);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_push <= 1'b1;
      req_func <= f;
      req_key <= k;
      do @(posedge clock); while (req_full);
      sb.note_request(f, k);
      burst_left--;
      sent++;
      if (burst_left == 0) req_push <= 1'b0;
   endtask

   task automatic drain();
      if (burst_left != 0) req_push <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
   endtask

   task automatic set_size(int unsigned v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v[8:0];
      @(posedge clock);
      sb.size_reg = v;
      csr_we <= 1'b0;
   endtask

   function automatic bit [63:0] rand_key();
      bit [63:0] k;
      int        len;
      k = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0: begin
            len = $urandom_range(0, 8);
            for (int i = 0; i < 8; i++) begin
               if (i >= len) k[8*i +: 8] = 8'd0;
               else if (k[8*i +: 8] == 8'd0) k[8*i +: 8] = 8'd1;
            end
         end
         1: k = k;
         default: ;
      endcase
      return k;
   endfunction

   task automatic random_phase(int count, int pool_n);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 85)
            send(func_type'($urandom_range(0, 2)), key_pool[$urandom_range(0, pool_n - 1)]);
         else if (r < 97)
            send(func_type'($urandom_range(0, 2)), rand_key());
         else
            send(FUNC_NONE, rand_key());
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_push = 1'b0;
      req_func = FUNC_LOOKUP;
      req_key = '0;
      burst_left = 0;
      sent = 0;
      for (int i = 0; i < 32; i++) begin
         key_pool[i] = {$urandom, $urandom};
         for (int j = 0; j < 8; j++) if (key_pool[i][8*j +: 8] == 8'd0) key_pool[i][8*j +: 8] = 8'hff;
         if (i % 3 == 0) key_pool[i][8*$urandom_range(1, 7) +: 8] = 8'd0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (600) @(posedge clock);

      // directed: empty key, full-width keys, duplicate, remove, tombstone reuse, bad func
      send(FUNC_LOOKUP, 64'd0);
      send(FUNC_INSERT, 64'd0);
      send(FUNC_REMOVE, 64'd0);
      send(FUNC_INSERT, 64'hffff_ffff_ffff_ffff);
      send(FUNC_INSERT, 64'hffff_ffff_ffff_ffff);
      send(FUNC_LOOKUP, 64'h00ff_ffff_ffff_ffff);
      send(FUNC_INSERT, 64'h0101_0101_0101_0101);
      send(FUNC_INSERT, 64'h4142_0000_0043);
      send(FUNC_LOOKUP, 64'h43);
      send(FUNC_REMOVE, 64'hffff_ffff_ffff_ffff);
      send(FUNC_LOOKUP, 64'hffff_ffff_ffff_ffff);
      send(FUNC_REMOVE, 64'hffff_ffff_ffff_ffff);
      send(FUNC_NONE, 64'h1234);
      set_size(1);
      send(FUNC_INSERT, 64'h55);
      send(FUNC_INSERT, 64'h66);
      send(FUNC_LOOKUP, 64'h66);
      send(FUNC_REMOVE, 64'h55);
      send(FUNC_INSERT, 64'h66);
      set_size(0);
      send(FUNC_LOOKUP, 64'h66);
      send(FUNC_INSERT, 64'h77);
      set_size(511);
      send(FUNC_LOOKUP, 64'h0101_0101_0101_0101);
      send(FUNC_INSERT, 64'h8000_0000_0000_0080);

      set_size(5);
      random_phase(200, 12);
      set_size(3);
      random_phase(150, 6);
      set_size(256);
      random_phase(250, 32);
      set_size(17);
      random_phase(200, 32);
      set_size(2);
      random_phase(100, 4);
      set_size(300);
      random_phase(125, 32);
      drain();
      $display("sent %0d requests over table sizes 0..511, checked %0d responses",
               sent, sb.checked);
      if (sb.errors == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/ohs_pkg.sv
rtl/core/ohs_front.sv
rtl/core/ohs_back.sv
rtl/core/ohs_queue.sv
rtl/core/open_address_hash_set_unit.sv
test/tb_top.sv
